// ===== sv/pls_pkg.sv =====
// ----------------------------------------------------------------------------
// pls_pkg: shared types for the positional list store
// Operation and status codes plus the result record passed from the
// sequencer to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package pls_pkg;

  // request operations
  typedef enum logic [2:0] {
    OP_INSERT   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_RETRIEVE = 3'd2,
    OP_REPLACE  = 3'd3,
    OP_CLEAR    = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned COUNT_W = 5;

  // one result item
  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    status_t                  status;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
  } pls_res_t;

endpackage

`default_nettype wire

// ===== sv/pls_ram.sv =====
// ----------------------------------------------------------------------------
// pls_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== sv/pls_ctrl.sv =====
// ----------------------------------------------------------------------------
// pls_ctrl: list sequencer
// Checks each request against the entry count, then moves entries one at a
// time through the list RAM with a single shared address stepper.
// ----------------------------------------------------------------------------
`default_nettype none

module pls_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  output logic                                     req_stall,
  input  wire logic [2:0]                          op,
  input  wire logic [pls_pkg::POS_W-1:0]           position,
  input  wire logic signed [pls_pkg::DATA_W-1:0]   value_in,
  output logic                                     res_valid,
  input  wire logic                                res_ack,
  output pls_pkg::pls_res_t                        res
);

  import pls_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_UP_RD,
    S_UP_WR,
    S_PUT,
    S_FETCH,
    S_GRAB,
    S_DN_RD,
    S_DN_WR,
    S_DONE
  } state_t;

  state_t                   state;
  op_t                      op_q;
  logic [POS_W-1:0]         pos_q;
  logic [DATA_W-1:0]        val_q;
  logic [CW-1:0]            count;
  logic [AW-1:0]            cur;
  logic [DATA_W-1:0]        rd_val;
  status_t                  status_q;

  logic [XW-1:0]            pos_x;
  logic [XW-1:0]            cnt_x;
  logic [AW-1:0]            pos_a;
  logic [AW-1:0]            adj;
  logic [XW-1:0]            adj_x;
  logic                     step_down;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [DATA_W-1:0]        wdata;
  logic [AW-1:0]            raddr;
  logic [DATA_W-1:0]        rdata;

  assign pos_x = XW'(pos_q);
  assign cnt_x = XW'(count);
  assign pos_a = pos_x[AW-1:0];

  // shared address stepper: down while opening a gap, up while closing one
  assign step_down = (state == S_UP_RD) || (state == S_UP_WR);
  assign adj       = step_down ? (cur - AW'(1)) : (cur + AW'(1));
  assign adj_x     = XW'(adj);

  // no item is taken while reset is held or a request is in progress
  assign req_stall = rst || (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  // result record
  always_comb begin
    res.read_value  = rd_val;
    res.status      = status_q;
    res.entry_count = cnt_x[COUNT_W-1:0];
    res.is_empty    = (count == '0);
  end

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = cur;
    wdata = rdata;
    raddr = adj;
    case (state)
      S_EXEC: begin
        if (op_q == OP_REPLACE && pos_x < cnt_x) begin
          we    = 1'b1;
          waddr = pos_a;
          wdata = val_q;
        end
      end
      S_UP_WR, S_DN_WR: begin
        we = 1'b1;
      end
      S_PUT: begin
        we    = 1'b1;
        waddr = pos_a;
        wdata = val_q;
      end
      S_FETCH: begin
        raddr = pos_a;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_q     <= op_t'(op);
            pos_q    <= position;
            val_q    <= value_in;
            rd_val   <= '0;
            status_q <= ST_OK;
            state    <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (op_q)
            OP_INSERT: begin
              if (cnt_x == XW'(DEPTH)) begin
                status_q <= ST_FULL;
                state    <= S_DONE;
              end else if (pos_x > cnt_x) begin
                status_q <= ST_RANGE;
                state    <= S_DONE;
              end else if (pos_x == cnt_x) begin
                state <= S_PUT;
              end else begin
                cur   <= cnt_x[AW-1:0];
                state <= S_UP_RD;
              end
            end
            OP_DELETE, OP_RETRIEVE: begin
              if (pos_x >= cnt_x) begin
                status_q <= ST_RANGE;
                state    <= S_DONE;
              end else begin
                state <= S_FETCH;
              end
            end
            OP_REPLACE: begin
              if (pos_x >= cnt_x) begin
                status_q <= ST_RANGE;
              end
              state <= S_DONE;
            end
            OP_CLEAR: begin
              count <= '0;
              state <= S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_UP_RD: begin
          state <= S_UP_WR;
        end
        S_UP_WR: begin
          cur <= adj;
          if (adj_x == pos_x) begin
            state <= S_PUT;
          end else begin
            state <= S_UP_RD;
          end
        end
        S_PUT: begin
          count <= count + CW'(1);
          state <= S_DONE;
        end
        S_FETCH: begin
          state <= S_GRAB;
        end
        S_GRAB: begin
          rd_val <= rdata;
          cur    <= pos_a;
          if (op_q == OP_RETRIEVE) begin
            state <= S_DONE;
          end else if ((pos_x + XW'(1)) < cnt_x) begin
            state <= S_DN_RD;
          end else begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_DN_RD: begin
          state <= S_DN_WR;
        end
        S_DN_WR: begin
          cur <= adj;
          if ((adj_x + XW'(1)) < cnt_x) begin
            state <= S_DN_RD;
          end else begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // list storage
  pls_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// ===== sv/positional_list_store.sv =====
// ----------------------------------------------------------------------------
// positional_list_store: ordered list of signed 32-bit values
// Insert, delete, retrieve, replace and clear by position, one item at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_stall) carries op, position, value_in.
//   Response channel (rsp_valid/rsp_stall) carries read_value, status,
//   entry_count and is_empty; every request gives exactly one response.
//   Entries are kept in order in a single-port-pair RAM and moved one at a
//   time by the sequencer (read, then write one place over). An insert
//   moves the entries from position p onward up one place, a delete moves
//   those after p down one place; retrieve, replace, clear and any error
//   move no entries. The request side stalls until the result is registered.
//   A response waits in the output register while rsp_stall is high; the
//   sequencer holds its finished result until the register frees up, and
//   meanwhile stalls new requests.
//   Reset (rst, synchronous) empties the list; RAM contents are not cleared,
//   since no entry is read before it has been written.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                req_valid,
  output logic                                     req_stall,
  input  wire logic [2:0]                          op,
  input  wire logic [pls_pkg::POS_W-1:0]           position,
  input  wire logic signed [pls_pkg::DATA_W-1:0]   value_in,
  output logic                                     rsp_valid,
  input  wire logic                                rsp_stall,
  output logic signed [pls_pkg::DATA_W-1:0]        read_value,
  output logic [1:0]                               status,
  output logic [pls_pkg::COUNT_W-1:0]              entry_count,
  output logic                                     is_empty
);

  import pls_pkg::*;

  pls_res_t res;
  pls_res_t rsp_q;
  logic     res_valid;
  logic     res_ack;

  // result moves into the output register when it is empty or draining
  assign res_ack = res_valid && (!rsp_valid || !rsp_stall);

  pls_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .op        (op),
    .position  (position),
    .value_in  (value_in),
    .res_valid (res_valid),
    .res_ack   (res_ack),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      if (res_ack) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (res_ack) begin
      rsp_q <= res;
    end
  end

  assign read_value  = rsp_q.read_value;
  assign status      = rsp_q.status;
  assign entry_count = rsp_q.entry_count;
  assign is_empty    = rsp_q.is_empty;

endmodule

`default_nettype wire
